// ----- design/ifd_pkg.sv -----
`default_nettype none

package ifd_pkg;

   // frame layout
   localparam int FRAME_BYTES = 20;
   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam int FIRST_KEPT = 1;   // lowest byte that feeds a sample
   localparam int LAST_KEPT = 18;   // highest stored byte that feeds a sample
   localparam int AXES = 3;

   // field widths
   localparam int BYTE_W = 8;
   localparam int SAMPLE_W = 20;
   localparam int ACC_BIAS_W = 20;
   localparam int RATE_BIAS_W = 29;
   localparam int ACC_OUT_W = 21;
   localparam int RATE_OUT_W = 30;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 29;
   localparam int RSP_FIELDS_W = AXES * (ACC_OUT_W + RATE_OUT_W);
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // rotation gain, 2^-16 dps per sample lsb
   localparam logic signed [RATE_OUT_W-1:0] RATE_GAIN = RATE_OUT_W'(500);

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_BIAS_X = 3'd0,
      CSR_ACCEL_BIAS_Y = 3'd1,
      CSR_ACCEL_BIAS_Z = 3'd2,
      CSR_RATE_BIAS_X  = 3'd3,
      CSR_RATE_BIAS_Y  = 3'd4,
      CSR_RATE_BIAS_Z  = 3'd5
   } csr_index_type;

   // raw samples of one frame, axis 0 is x
   typedef struct packed {
      logic [AXES-1:0][SAMPLE_W-1:0] accel;
      logic [AXES-1:0][SAMPLE_W-1:0] rate;
   } sample_type;

   // bias registers, axis 0 is x
   typedef struct packed {
      logic [AXES-1:0][ACC_BIAS_W-1:0]  accel;
      logic [AXES-1:0][RATE_BIAS_W-1:0] rate;
   } bias_type;

   // corrected result, axis 0 is x
   typedef struct packed {
      logic [AXES-1:0][ACC_OUT_W-1:0]  accel;
      logic [AXES-1:0][RATE_OUT_W-1:0] rate;
   } result_type;

endpackage

`default_nettype wire

// ----- design/ifd_frame_collect.sv -----
`default_nettype none

module ifd_frame_collect
   import ifd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_valid,
   output logic                   byte_ready,
   input  wire logic [BYTE_W-1:0] byte_data,
   output logic                   smp_valid,
   input  wire logic              smp_ready,
   output sample_type             smp_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [BYTE_W-1:0] store_ff [FIRST_KEPT:LAST_KEPT];
   logic smp_valid_ff, smp_valid_in;
   sample_type smp_ff, smp_in;
   logic accept;
   logic last_byte;

   // a full sample register that cannot drain holds off the stream
   assign byte_ready = !smp_valid_ff || smp_ready;
   assign accept = byte_valid && byte_ready;
   assign last_byte = (pos_ff == POS_W'(FRAME_BYTES - 1));

   // byte position within the frame
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (last_byte) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // sample assembly, the last shared byte is the word arriving now
   always_comb begin
      logic [AXES-1:0][BYTE_W-1:0] shared;
      shared[0] = store_ff[17];
      shared[1] = store_ff[18];
      shared[2] = byte_data;
      for (int k = 0; k < AXES; k++) begin
         smp_in.accel[k] = {store_ff[2 + 2 * k], store_ff[1 + 2 * k], shared[k][7:4]};
         smp_in.rate[k] = {store_ff[8 + 2 * k], store_ff[7 + 2 * k], shared[k][3:0]};
      end
   end

   // sample register valid
   always_comb begin
      smp_valid_in = smp_valid_ff;
      if (accept && last_byte) begin
         smp_valid_in = 1'b1;
      end else if (smp_ready) begin
         smp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         smp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         smp_valid_ff <= smp_valid_in;
      end
   end

   // frame bytes that feed samples
   always_ff @(posedge clock) begin
      for (int i = FIRST_KEPT; i <= LAST_KEPT; i++) begin
         if (accept && pos_ff == POS_W'(i)) begin
            store_ff[i] <= byte_data;
         end
      end
   end

   // sample payload
   always_ff @(posedge clock) begin
      if (accept && last_byte) begin
         smp_ff <= smp_in;
      end
   end

   assign smp_valid = smp_valid_ff;
   assign smp_data = smp_ff;

endmodule

`default_nettype wire

// ----- design/ifd_scale.sv -----
`default_nettype none

module ifd_scale
   import ifd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       smp_valid,
   output logic            smp_ready,
   input  wire sample_type smp_data,
   input  wire bias_type   bias,
   output logic            res_valid,
   input  wire logic       res_ready,
   output result_type      res_data
);

   logic res_valid_ff, res_valid_in;
   result_type res_ff, res_in;
   logic load;

   assign smp_ready = !res_valid_ff || res_ready;
   assign load = smp_valid && smp_ready;

   // bias removal and rotation gain per axis
   always_comb begin
      logic signed [ACC_OUT_W-1:0] acc_s;
      logic signed [ACC_OUT_W-1:0] acc_b;
      logic signed [RATE_OUT_W-1:0] rate_s;
      logic signed [RATE_OUT_W-1:0] rate_b;
      logic signed [RATE_OUT_W-1:0] rate_p;
      for (int k = 0; k < AXES; k++) begin
         acc_s = ACC_OUT_W'($signed(smp_data.accel[k]));
         acc_b = ACC_OUT_W'($signed(bias.accel[k]));
         res_in.accel[k] = acc_s - acc_b;
         rate_s = RATE_OUT_W'($signed(smp_data.rate[k]));
         rate_b = RATE_OUT_W'($signed(bias.rate[k]));
         rate_p = rate_s * RATE_GAIN;
         res_in.rate[k] = rate_p - rate_b;
      end
   end

   // result register valid
   always_comb begin
      res_valid_in = res_valid_ff;
      if (load) begin
         res_valid_in = 1'b1;
      end else if (res_ready) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_data = res_ff;

endmodule

`default_nettype wire

// ----- design/imu_fifo_frame_decoder_top.sv -----
// Motion sensor FIFO frame decoder.
// The req_ stream carries the raw sensor FIFO, one byte per word. Bytes are
// counted into 20-byte frames; on the last byte of a frame the six 20-bit
// samples are assembled, rotation is scaled by 500 and the bias registers
// are subtracted, giving one rsp_ word per frame. Other bytes give no word.
// Throughput: one byte per clock, sustained while the receiver keeps up.
// After the last byte of its frame is taken, the rsp_ word passes through
// the sample register and then the result register.
// The csr_ channel writes the six bias registers (accel x/y/z, then rate
// x/y/z); csr_ready is always high. Write them only while no frame result
// is pending. Indexes beyond the map are ignored.
// Reset puts the byte count at the start of a frame, clears all bias
// registers and empties both pipeline registers.
// When the receiver stalls, the result register holds its word; one more
// frame result can wait in the sample register, and after that req_tready
// drops until the result is taken. No word is dropped or repeated.
`default_nettype none

module imu_fifo_frame_decoder_top
   import ifd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // fifo_byte [7:0]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,
   // accel_out_x [20:0], accel_out_y [41:21], accel_out_z [62:42],
   // rate_out_x [92:63], rate_out_y [122:93], rate_out_z [152:123], zero [159:153]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   bias_type bias_ff, bias_in;
   logic smp_valid;
   logic smp_ready;
   sample_type smp_data;
   result_type res_data;

   // bias register writes
   assign csr_ready = 1'b1;

   always_comb begin
      bias_in = bias_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACCEL_BIAS_X: bias_in.accel[0] = csr_data[ACC_BIAS_W-1:0];
            CSR_ACCEL_BIAS_Y: bias_in.accel[1] = csr_data[ACC_BIAS_W-1:0];
            CSR_ACCEL_BIAS_Z: bias_in.accel[2] = csr_data[ACC_BIAS_W-1:0];
            CSR_RATE_BIAS_X:  bias_in.rate[0] = csr_data[RATE_BIAS_W-1:0];
            CSR_RATE_BIAS_Y:  bias_in.rate[1] = csr_data[RATE_BIAS_W-1:0];
            CSR_RATE_BIAS_Z:  bias_in.rate[2] = csr_data[RATE_BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   // byte counting and sample assembly
   ifd_frame_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .smp_valid  (smp_valid),
      .smp_ready  (smp_ready),
      .smp_data   (smp_data)
   );

   // gain, bias and result register
   ifd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .smp_valid (smp_valid),
      .smp_ready (smp_ready),
      .smp_data  (smp_data),
      .bias      (bias_ff),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_data  (res_data)
   );

   // pack result fields, x first
   assign rsp_tdata = {
      (RSP_DATA_W - RSP_FIELDS_W)'(0),
      res_data.rate[2], res_data.rate[1], res_data.rate[0],
      res_data.accel[2], res_data.accel[1], res_data.accel[0]
   };

endmodule

`default_nettype wire

// ----- tb/sv/imu_fifo_frame_decoder_checker.sv -----
module imu_fifo_frame_decoder_checker
   import ifd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          results_due,
   output int                          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // frame layout, byte offsets of axis x; y and z follow two bytes apart
   localparam int     ACC_MID_BYTE  = 1;
   localparam int     ACC_HI_BYTE   = 2;
   localparam int     RATE_MID_BYTE = 7;
   localparam int     RATE_HI_BYTE  = 8;
   localparam int     AXIS_STEP     = 2;
   localparam int     SHARED_BYTE   = 17;
   localparam longint ROT_GAIN      = 500;
   localparam int     RATE_BASE     = AXES * ACC_OUT_W;
   // keep the log readable when the block is badly off
   localparam int     REPORT_LIMIT  = 60;

   logic [POS_W-1:0]  byte_pos;
   logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
   bias_type          bias;
   result_type        frames_due [$];
   int                mismatches = 0;
   int                reports = 0;

   // corrected samples of the frame now complete in frame_bytes
   function automatic result_type decode_frame();
      result_type                    r;
      logic [BYTE_W-1:0]             shared;
      logic signed [SAMPLE_W-1:0]    acc_raw;
      logic signed [SAMPLE_W-1:0]    rate_raw;
      logic signed [ACC_BIAS_W-1:0]  acc_off;
      logic signed [RATE_BIAS_W-1:0] rate_off;
      longint                        acc;
      longint                        rate;
      for (int k = 0; k < AXES; k++) begin
         shared   = frame_bytes[SHARED_BYTE + k];
         // upper nibble of the shared byte is acceleration, lower is rotation
         acc_raw  = {frame_bytes[ACC_HI_BYTE + AXIS_STEP * k],
                     frame_bytes[ACC_MID_BYTE + AXIS_STEP * k], shared[7:4]};
         rate_raw = {frame_bytes[RATE_HI_BYTE + AXIS_STEP * k],
                     frame_bytes[RATE_MID_BYTE + AXIS_STEP * k], shared[3:0]};
         acc_off  = bias.accel[k];
         rate_off = bias.rate[k];
         acc  = longint'(acc_raw) - longint'(acc_off);
         rate = longint'(rate_raw) * ROT_GAIN - longint'(rate_off);
         r.accel[k] = acc[ACC_OUT_W-1:0];
         r.rate[k]  = rate[RATE_OUT_W-1:0];
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         if (reports < REPORT_LIMIT)
            $display("%0t rsp word %s: expected %0d actual %0d", $time, name, want, got);
         reports++;
      end
   endtask

   // compare one result word with the oldest frame still due
   task automatic check_word(input logic [RSP_DATA_W-1:0] word);
      result_type want;
      if (frames_due.size() == 0) begin
         mismatches++;
         if (reports < REPORT_LIMIT)
            $display("%0t rsp word with no frame due: expected none actual %h", $time, word);
         reports++;
         return;
      end
      want = frames_due.pop_front();
      for (int k = 0; k < AXES; k++) begin
         check_field($sformatf("accel_out_%c", "x" + k), $signed(want.accel[k]),
                     $signed(word[k * ACC_OUT_W +: ACC_OUT_W]));
         check_field($sformatf("rate_out_%c", "x" + k), $signed(want.rate[k]),
                     $signed(word[RATE_BASE + k * RATE_OUT_W +: RATE_OUT_W]));
      end
      check_field("padding", 0, word[RSP_DATA_W-1:RSP_FIELDS_W]);
   endtask

   // track registers, byte count and frame store; compare result words
   always @(posedge clock) begin
      if (reset) begin
         byte_pos = '0;
         bias     = '0;
         frames_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL_BIAS_X: bias.accel[0] = csr_data[ACC_BIAS_W-1:0];
               CSR_ACCEL_BIAS_Y: bias.accel[1] = csr_data[ACC_BIAS_W-1:0];
               CSR_ACCEL_BIAS_Z: bias.accel[2] = csr_data[ACC_BIAS_W-1:0];
               CSR_RATE_BIAS_X:  bias.rate[0]  = csr_data[RATE_BIAS_W-1:0];
               CSR_RATE_BIAS_Y:  bias.rate[1]  = csr_data[RATE_BIAS_W-1:0];
               CSR_RATE_BIAS_Z:  bias.rate[2]  = csr_data[RATE_BIAS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready)
            check_word(rsp_tdata);
         if (req_tvalid && req_tready) begin
            frame_bytes[byte_pos] = req_tdata;
            // last byte closes the frame and wraps the count
            if (byte_pos == POS_W'(FRAME_BYTES - 1)) begin
               byte_pos = '0;
               frames_due.push_back(decode_frame());
            end else begin
               byte_pos = byte_pos + 1'b1;
            end
         end
      end
      results_due <= frames_due.size();
      fail_count  <= mismatches;
   end

endmodule

// ----- tb/sv/tb_imu_fifo_frame_decoder_top.sv -----
module tb_imu_fifo_frame_decoder_top
   import ifd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HIGH      = 5;
   localparam int CLK_LOW       = 5;
   localparam int RESET_CYCLES  = 9;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PCT      = 30;
   localparam int BIAS_PHASES   = 8;
   localparam int RUN_MIN       = 175;
   localparam int RUN_MAX       = 255;
   // sender never idles between these byte counts
   localparam int CALM_FROM     = 700;
   localparam int CALM_TO       = 1000;
   // receiver holds off once after this many words, never idles in its calm range
   localparam int HOLD_AFTER    = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int RX_CALM_FROM  = 50;
   localparam int RX_CALM_TO    = 70;

   localparam logic signed [ACC_BIAS_W-1:0]  ACC_IN_MAX    = ACC_BIAS_W'(524287);
   localparam logic signed [ACC_BIAS_W-1:0]  ACC_IN_MIN    = ACC_BIAS_W'(-524288);
   localparam int                            RATE_IN_MAX   = 262144000;
   localparam logic signed [RATE_BIAS_W-1:0] RATE_FULL_MAX = {1'b0, {(RATE_BIAS_W-1){1'b1}}};
   localparam logic signed [RATE_BIAS_W-1:0] RATE_FULL_MIN = {1'b1, {(RATE_BIAS_W-1){1'b0}}};

   localparam logic [BYTE_W-1:0] CORNER_BYTES [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

   // accel x min, y max, z minus one; rate x max, y min, z zero
   localparam logic [BYTE_W-1:0] DIRECTED_FRAME [FRAME_BYTES] = '{
      8'hFF,                       // header, ignored
      8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
      8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h00,
      8'hFF, 8'h00, 8'hAA, 8'h55,  // temperature and timestamp, ignored
      8'h0F, 8'hF0, 8'hF0          // shared nibbles
   };

   typedef enum int {
      BIAS_TOP, BIAS_BOTTOM, BIAS_FULL_TOP, BIAS_FULL_BOTTOM, BIAS_SPREAD, BIAS_ANY
   } bias_mode_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int results_due;
   int fail_count;
   int bytes_sent   = 0;
   int words_taken  = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   imu_fifo_frame_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   imu_fifo_frame_decoder_checker decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .results_due (results_due),
      .fail_count  (fail_count)
   );

   // clock
   always begin
      clock = 1'b0;
      #CLK_LOW;
      clock = 1'b1;
      #CLK_HIGH;
   end

   // receiver: random stalls, one long hold-off, one calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_taken++;
            if (words_taken == HOLD_AFTER)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (words_taken >= RX_CALM_FROM && words_taken < RX_CALM_TO) ||
                          ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL imu_fifo_frame_decoder_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [BYTE_W-1:0] random_byte();
      if ($urandom_range(3) == 0)
         return CORNER_BYTES[$urandom_range(3)];
      return BYTE_W'($urandom);
   endfunction

   // bias word for one register; bits above the register width stay random
   function automatic logic [CSR_DATA_W-1:0] pick_bias(input bias_mode_type mode,
                                                       input bit is_rate);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      if (is_rate) begin
         case (mode)
            BIAS_TOP:         word = CSR_DATA_W'(RATE_IN_MAX);
            BIAS_BOTTOM:      word = CSR_DATA_W'(-RATE_IN_MAX);
            BIAS_FULL_TOP:    word = RATE_FULL_MAX;
            BIAS_FULL_BOTTOM: word = RATE_FULL_MIN;
            BIAS_SPREAD:
               word = CSR_DATA_W'(int'($urandom_range(2 * RATE_IN_MAX)) - RATE_IN_MAX);
            default: ;
         endcase
      end else begin
         case (mode)
            BIAS_TOP, BIAS_FULL_TOP:       word[ACC_BIAS_W-1:0] = ACC_IN_MAX;
            BIAS_BOTTOM, BIAS_FULL_BOTTOM: word[ACC_BIAS_W-1:0] = ACC_IN_MIN;
            default: ;
         endcase
      end
      return word;
   endfunction

   // every index the channel can carry, the unmapped ones too
   task automatic load_biases(input bias_mode_type mode);
      for (int i = 0; i < (1 << CSR_INDEX_W); i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data  <= pick_bias(mode, i >= CSR_RATE_BIAS_X);
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      bit calm;
      calm = bytes_sent >= CALM_FROM && bytes_sent < CALM_TO;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_run(input int count);
      for (int i = 0; i < count; i++)
         send_byte(random_byte());
   endtask

   // stop offering, wait for every due result, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      bias_mode_type mode;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner frame under reset biases, then random bytes
      for (int i = 0; i < FRAME_BYTES; i++)
         send_byte(DIRECTED_FRAME[i]);
      send_run($urandom_range(RUN_MIN, RUN_MAX));

      // extreme bias settings first, random ones after
      for (int p = 0; p < BIAS_PHASES; p++) begin
         wait_idle();
         if (p <= BIAS_FULL_BOTTOM)
            mode = bias_mode_type'(p);
         else
            mode = bias_mode_type'($urandom_range(BIAS_SPREAD, BIAS_ANY));
         load_biases(mode);
         send_run($urandom_range(RUN_MIN, RUN_MAX));
      end

      wait_idle();
      if (fail_count == 0 && results_due == 0)
         $display("PASS imu_fifo_frame_decoder_top");
      else
         $display("FAIL imu_fifo_frame_decoder_top");
      $finish;
   end

endmodule
